>>> rtl/core/mwpo_pkg.sv
// Shared types and codes for the multi-wave phase oscillator.
// Used by the register block, the controller, the datapath and the top level.
package mwpo_pkg;

	localparam int REG_IDX_W = 3;

	// Register indexes on the configuration port
	typedef enum logic [REG_IDX_W-1:0] {
		REG_OSC_ENABLED     = 3'd0,
		REG_WAVE_SELECT     = 3'd1,
		REG_PITCH_OFFSET    = 3'd2,
		REG_VOLUME          = 3'd3,
		REG_INV_SAMPLE_RATE = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_NOTE_ON  = 2'd1,
		ACT_NOTE_OFF = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		WAVE_SAW      = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_SINE     = 2'd3
	} wave_t;

	// Datapath steps of one tick, in order
	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_OCT,
		STEP_SCALE,
		STEP_DIV,
		STEP_LOOK,
		STEP_FREQ,
		STEP_MLO,
		STEP_MHI,
		STEP_ACC,
		STEP_SHIFT,
		STEP_PHASE,
		STEP_SIDX,
		STEP_WAVE,
		STEP_GAIN
	} step_t;

	typedef struct packed {
		logic               osc_enabled;
		wave_t              wave_select;
		logic signed [12:0] pitch_offset;
		logic [15:0]        volume;
		logic [39:0]        inv_sample_rate;
	} cfg_t;

	localparam logic        RST_OSC_ENABLED = 1'b1;
	localparam wave_t       RST_WAVE_SELECT = WAVE_SAW;
	localparam logic [12:0] RST_PITCH_OFFSET = 13'd0;
	localparam logic [15:0] RST_VOLUME = 16'd52429;
	localparam logic [39:0] RST_INV_SAMPLE_RATE = 40'd0;

	typedef struct packed {
		logic  note_on;
		logic  note_off;
		logic  load_out;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic inv_zero;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/mwpo_cfg.sv
// Configuration register file of the oscillator.
// Depends on mwpo_pkg for the register indexes and the cfg_t layout.
module mwpo_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [mwpo_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [39:0]                      cfg_data,
	output logic                             cfg_ready,
	output mwpo_pkg::cfg_t                   cfg,
	output logic                             inv_zero
);
	import mwpo_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;
	assign inv_zero = (cfg_q.inv_sample_rate == 40'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.osc_enabled <= RST_OSC_ENABLED;
			cfg_q.wave_select <= RST_WAVE_SELECT;
			cfg_q.pitch_offset <= $signed(RST_PITCH_OFFSET);
			cfg_q.volume <= RST_VOLUME;
			cfg_q.inv_sample_rate <= RST_INV_SAMPLE_RATE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OSC_ENABLED: cfg_q.osc_enabled <= cfg_data[0];
				REG_WAVE_SELECT: cfg_q.wave_select <= wave_t'(cfg_data[1:0]);
				REG_PITCH_OFFSET: cfg_q.pitch_offset <= $signed(cfg_data[12:0]);
				REG_VOLUME: cfg_q.volume <= cfg_data[15:0];
				REG_INV_SAMPLE_RATE: cfg_q.inv_sample_rate <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/mwpo_ctrl.sv
// Controller of the oscillator: input handshake and the step sequence of a tick.
// Depends on mwpo_pkg for the action codes and the command and status structs.
module mwpo_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     action,
	input  mwpo_pkg::sts_t sts,
	output logic           in_stall,
	output mwpo_pkg::cmd_t cmd
);
	import mwpo_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} state_t;

	state_t state_q;
	step_t  step_q;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd.note_on = accept && (action == ACT_NOTE_ON);
		cmd.note_off = accept && (action == ACT_NOTE_OFF);
		cmd.load_out = (state_q == ST_OUT) && sts.out_free;
		cmd.step = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// a tick before the sample rate is known is dropped
					if (accept && (action == ACT_TICK) && !sts.inv_zero) begin
						state_q <= ST_RUN;
						step_q <= STEP_OCT;
					end
				end
				ST_RUN: begin
					case (step_q)
						STEP_OCT: step_q <= STEP_SCALE;
						STEP_SCALE: step_q <= STEP_DIV;
						STEP_DIV: step_q <= STEP_LOOK;
						STEP_LOOK: step_q <= STEP_FREQ;
						STEP_FREQ: step_q <= STEP_MLO;
						STEP_MLO: step_q <= STEP_MHI;
						STEP_MHI: step_q <= STEP_ACC;
						STEP_ACC: step_q <= STEP_SHIFT;
						STEP_SHIFT: step_q <= STEP_PHASE;
						STEP_PHASE: step_q <= STEP_SIDX;
						STEP_SIDX: step_q <= STEP_WAVE;
						STEP_WAVE: step_q <= STEP_GAIN;
						STEP_GAIN: begin
							step_q <= STEP_IDLE;
							state_q <= ST_OUT;
						end
						default: begin
							step_q <= STEP_IDLE;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_OUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					step_q <= STEP_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/mwpo_dp.sv
// Datapath of the oscillator: note state, pitch to phase step, phase
// accumulator, waveform forming, gain and the output register.
// Depends on mwpo_pkg for cfg_t, cmd_t and the step and wave codes.
module mwpo_dp #(
	parameter int PHASE_BITS       = 32,
	parameter int SAMPLE_BITS      = 16,
	parameter int EXP_TABLE_DEPTH  = 256,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mwpo_pkg::cmd_t cmd,
	input  mwpo_pkg::cfg_t cfg,
	input  logic [6:0]     note_number,
	input  logic           out_stall,
	output logic           out_valid,
	output logic [15:0]    sample,
	output logic           out_free
);
	import mwpo_pkg::*;

	localparam int EI_W = $clog2(EXP_TABLE_DEPTH);
	localparam int RD_W = $clog2(3 * EXP_TABLE_DEPTH);
	localparam int RP_W = 12 + $clog2(EXP_TABLE_DEPTH + 1);
	localparam int SI_W = $clog2(SINE_TABLE_DEPTH);
	localparam int SM_W = 32 + $clog2(SINE_TABLE_DEPTH + 1);
	localparam int YW = SAMPLE_BITS + 1;
	localparam int PW = YW + 17;

	localparam logic [63:0] LN2_Q30 = 64'd744261118;
	localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	typedef logic [31:0] exp_rom_t [EXP_TABLE_DEPTH];
	typedef logic signed [YW-1:0] sine_rom_t [SINE_TABLE_DEPTH];

	// shift-subtract quotient, only evaluated while the tables are built
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// 2^(i/depth) in Q30, series sum
	function automatic exp_rom_t build_exp();
		exp_rom_t    tab;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] sum;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			y = udiv64(LN2_Q30 * 64'(i), 64'(EXP_TABLE_DEPTH));
			term = ONE_Q30;
			sum = ONE_Q30;
			for (int k = 1; k <= 20; k++) begin
				term = udiv64((term * y) >> 30, 64'(k));
				sum = sum + term;
			end
			tab[i] = sum[31:0];
		end
		return tab;
	endfunction

	// round(H * sin(2 pi k / depth)), quarter folded, series sum
	function automatic sine_rom_t build_sine();
		sine_rom_t          tab;
		logic [63:0]        f;
		logic [63:0]        quad;
		logic [63:0]        r;
		logic [63:0]        th;
		logic [63:0]        th2;
		logic [63:0]        term;
		logic signed [63:0] s;
		logic signed [63:0] v;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			f = udiv64(64'(i) << 32, 64'(SINE_TABLE_DEPTH));
			quad = (f >> 30) & 64'd3;
			r = f & (ONE_Q30 - 64'd1);
			if (quad[0]) begin
				r = ONE_Q30 - r;
			end
			th = (r * HALFPI_Q30) >> 30;
			th2 = (th * th) >> 30;
			term = th;
			s = $signed(th);
			for (int k = 1; k <= 10; k++) begin
				term = udiv64((term * th2) >> 30, 64'(2 * k) * 64'(2 * k + 1));
				if ((k & 1) != 0) begin
					s = s - $signed(term);
				end else begin
					s = s + $signed(term);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			if (s > $signed(ONE_Q30)) begin
				s = $signed(ONE_Q30);
			end
			v = (s * (64'sd1 <<< (SAMPLE_BITS - 1)) + (64'sd1 <<< 29)) >>> 30;
			tab[i] = (quad >= 64'd2) ? YW'(-v) : YW'(v);
		end
		return tab;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp();
	localparam sine_rom_t SIN_ROM = build_sine();

	localparam logic signed [YW-1:0] HY = {2'b01, {(SAMPLE_BITS - 1){1'b0}}};
	localparam logic signed [YW:0] HT = (YW + 1)'(HY);
	localparam logic signed [YW:0] VMAX = (YW + 1)'(HT - 1);
	localparam logic signed [YW:0] VMIN = (YW + 1)'(-HT);

	// note and phase state
	logic [6:0]            held_q;
	logic                  gate_q;
	logic [PHASE_BITS-1:0] phase_q;

	// working registers of a tick
	logic [3:0]            oct_q;
	logic [11:0]           r_q;
	logic [RD_W-1:0]       rd_q;
	logic [EI_W-1:0]       idx_q;
	logic [31:0]           exp_q;
	logic [26:0]           f16_q;
	logic [66:0]           prod_q;
	logic [46:0]           pp_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [SI_W-1:0]       sidx_q;
	logic signed [YW-1:0]  y_q;
	logic signed [PW-1:0]  prod2_q;

	logic                  out_valid_q;
	logic [15:0]           sample_q;

	logic [16:0]           e_w;
	logic [12:0]           qm_w;
	logic [3:0]            q_w;
	logic [15:0]           r_w;
	logic [RP_W-1:0]       rp_w;
	logic [RD_W+16:0]      dm_w;
	logic [40:0]           fm_w;
	logic [5:0]            sh_w;
	logic [PHASE_BITS+31:0] pext_w;
	logic [31:0]           u_w;
	logic [SM_W-1:0]       sm_w;
	logic signed [YW-1:0]  saw_w;
	logic signed [YW-1:0]  sqr_w;
	logic signed [YW:0]    tri_w;
	logic [15:0]           gain_w;
	logic signed [YW:0]    v_w;
	logic signed [SAMPLE_BITS-1:0] sat_w;
	logic [SAMPLE_BITS+15:0] al_w;

	always_comb begin
		// e = pitch - 69 semitones + 8 octaves, always positive
		e_w = {2'b00, held_q, 8'b0} + 17'(cfg.pitch_offset) + 17'd6912;
		// octave = e / 3072 = (e >> 10) / 3
		qm_w = 13'(e_w[15:10]) * 13'd43;
		q_w = qm_w[10:7];
		r_w = e_w[15:0] - 16'(q_w) * 16'd3072;
		rp_w = RP_W'(r_q) * RP_W'(EXP_TABLE_DEPTH);
		dm_w = (RD_W + 17)'(rd_q) * (RD_W + 17)'(43691);
		fm_w = 41'(exp_q) * 41'd440;
		sh_w = 6'(7'(72 - PHASE_BITS) - 7'(oct_q));
		pext_w = {phase_q, 32'b0};
		u_w = pext_w[PHASE_BITS+31 -: 32];
		sm_w = SM_W'(u_w) * SM_W'(SINE_TABLE_DEPTH);
		saw_w = $signed({1'b0, u_w[31 -: SAMPLE_BITS]}) - HY;
		sqr_w = u_w[31] ? -HY : HY;
		if (!u_w[31]) begin
			tri_w = $signed({1'b0, u_w[31 -: YW]}) - HT;
		end else begin
			tri_w = HT + HT + HT - $signed({1'b0, u_w[31 -: YW]});
		end
		gain_w = (cfg.osc_enabled && gate_q) ? cfg.volume : 16'd0;
		v_w = (YW + 1)'(prod2_q >>> 16);
		if (v_w > VMAX) begin
			sat_w = SAMPLE_BITS'(VMAX);
		end else if (v_w < VMIN) begin
			sat_w = SAMPLE_BITS'(VMIN);
		end else begin
			sat_w = SAMPLE_BITS'(v_w);
		end
		al_w = {sat_w, 16'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 7'd0;
			gate_q <= 1'b0;
			phase_q <= '0;
		end else begin
			if (cmd.note_on) begin
				held_q <= note_number;
				gate_q <= 1'b1;
			end else if (cmd.note_off && (note_number == held_q)) begin
				gate_q <= 1'b0;
			end
			if (cmd.step == STEP_PHASE) begin
				phase_q <= phase_q + step_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.step)
			STEP_OCT: begin
				oct_q <= q_w;
				r_q <= r_w[11:0];
			end
			STEP_SCALE: rd_q <= RD_W'(rp_w >> 10);
			STEP_DIV: idx_q <= EI_W'(dm_w >> 17);
			STEP_LOOK: exp_q <= EXP_ROM[idx_q];
			STEP_FREQ: f16_q <= fm_w[40:14];
			STEP_MLO: prod_q <= 67'(47'(f16_q) * 47'(cfg.inv_sample_rate[19:0]));
			STEP_MHI: pp_q <= 47'(f16_q) * 47'(cfg.inv_sample_rate[39:20]);
			STEP_ACC: prod_q <= prod_q + {pp_q, 20'b0};
			STEP_SHIFT: step_q <= PHASE_BITS'(prod_q >> sh_w);
			STEP_SIDX: sidx_q <= SI_W'(sm_w >> 32);
			STEP_WAVE: begin
				case (cfg.wave_select)
					WAVE_SAW: y_q <= saw_w;
					WAVE_SQUARE: y_q <= sqr_w;
					WAVE_TRIANGLE: y_q <= tri_w[YW-1:0];
					WAVE_SINE: y_q <= SIN_ROM[sidx_q];
					default: y_q <= saw_w;
				endcase
			end
			STEP_GAIN: prod2_q <= PW'(y_q) * PW'($signed({1'b0, gain_w}));
			default: ;
		endcase
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign sample = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sample_q <= al_w[SAMPLE_BITS+15 -: 16];
		end
	end

endmodule

>>> rtl/core/multi_wave_phase_oscillator.sv
// Monophonic saw/square/triangle/sine oscillator; top level.
// Note items do not stall the input. A tick runs from acceptance until its
// sample is loaded in the output register: 13 datapath steps (multiplies, table
// reads, the phase add), then the output load, which waits while the output
// stalls; the input stalls meanwhile, so no new item is taken until then. Reset (arst_n
// low, asynchronous) sets the registers to defaults, clears phase and note, closes the gate.
module multi_wave_phase_oscillator #(
	parameter int PHASE_BITS       = 32,
	parameter int SAMPLE_BITS      = 16,
	parameter int EXP_TABLE_DEPTH  = 256,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [6:0]                     note_number,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             sample,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mwpo_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [39:0]                    cfg_data
);
	import mwpo_pkg::*;

	cfg_t        cfg;
	cmd_t        cmd;
	sts_t        sts;
	logic        inv_zero;
	logic        out_free;
	logic [15:0] sample_w;

	assign sts.inv_zero = inv_zero;
	assign sts.out_free = out_free;
	assign sample = $signed(sample_w);

	mwpo_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg),
		.inv_zero  (inv_zero)
	);

	mwpo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	mwpo_dp #(
		.PHASE_BITS       (PHASE_BITS),
		.SAMPLE_BITS      (SAMPLE_BITS),
		.EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.note_number (note_number),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.sample      (sample_w),
		.out_free    (out_free)
	);

endmodule

>>> verif/osc_sample_checker.sv
// Scoreboard for the phase accumulator oscillator: it watches the note/tick, sample
// and register channels, predicts each tick's sample and compares it.
// Depends on mwpo_pkg for the register indexes, action codes and wave codes.
`timescale 1ns / 1ps

module osc_sample_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [6:0]                     note_number,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic signed [15:0]             sample,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [mwpo_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [39:0]                    cfg_data,
	output int                             samples_due_count,
	output int                             mismatches
);
	import mwpo_pkg::*;

	localparam longint unsigned LN2_Q30    = 64'd744261118;
	localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30    = 64'd1073741824;

	longint unsigned exp_q30 [256];
	int              sine_lut [1024];

	// register copies
	logic               osc_en;
	wave_t              wave_sel;
	logic signed [12:0] detune;
	logic [15:0]        gain;
	logic [39:0]        inv_rate;

	logic [31:0] phase;
	logic [6:0]  note_held;
	logic        gate;

	logic [15:0] samples_due [$];

	// octave exponent table (Q30) and quarter-wave folded sine table
	initial begin
		longint unsigned y, term, acc, fi, quad, r, th, th2;
		longint s, v;
		for (int i = 0; i < 256; i++) begin
			y = LN2_Q30 * longint'(i) / 256;
			term = ONE_Q30;
			acc = ONE_Q30;
			for (longint unsigned k = 1; k <= 20; k++) begin
				term = ((term * y) >> 30) / k;
				acc += term;
			end
			exp_q30[i] = acc;
		end
		for (int i = 0; i < 1024; i++) begin
			fi = longint'(i);
			fi = fi << 22;
			quad = (fi >> 30) & 3;
			r = fi & (ONE_Q30 - 1);
			if (quad[0])
				r = ONE_Q30 - r;
			th = (r * HALFPI_Q30) >> 30;
			th2 = (th * th) >> 30;
			term = th;
			s = th;
			for (longint unsigned k = 1; k <= 10; k++) begin
				term = ((term * th2) >> 30) / ((2 * k) * (2 * k + 1));
				if (k[0])
					s -= term;
				else
					s += term;
			end
			if (s < 0)
				s = 0;
			if (s > ONE_Q30)
				s = ONE_Q30;
			v = (s * 32768 + 536870912) >>> 30;
			sine_lut[i] = (quad >= 2) ? -v : v;
		end
	end

	// One tick: pitch -> phase step -> accumulate -> wave -> gain.
	function automatic logic [15:0] tick_sample();
		int              dd, ee, oct, idx, sh;
		longint unsigned f16;
		logic [127:0]    prod, shifted;
		longint          uu, t, y, g, v;
		dd = int'(note_held) * 256 + int'(detune) - 69 * 256;
		ee = dd + 8 * 3072;
		oct = ee / 3072 - 8;
		idx = (ee % 3072) * 256 / 3072;
		f16 = (64'd440 * exp_q30[idx]) >> 14;
		prod = {64'd0, f16} * {88'd0, inv_rate};
		sh = 32 - oct;
		shifted = prod >> sh;
		phase = phase + shifted[31:0];
		uu = phase;
		case (wave_sel)
			WAVE_SAW:    y = (uu >> 16) - 32768;
			WAVE_SQUARE: y = (uu < 64'h8000_0000) ? 32768 : -32768;
			WAVE_TRIANGLE: begin
				t = uu >> 15;
				y = (t < 65536) ? t - 32768 : 98304 - t;
			end
			default:     y = sine_lut[uu >> 22];
		endcase
		g = (osc_en && gate) ? longint'(gain) : 0;
		v = (y * g) >>> 16;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			osc_en = RST_OSC_ENABLED;
			wave_sel = RST_WAVE_SELECT;
			detune = RST_PITCH_OFFSET;
			gain = RST_VOLUME;
			inv_rate = RST_INV_SAMPLE_RATE;
			phase = '0;
			note_held = '0;
			gate = 1'b0;
			samples_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OSC_ENABLED:     osc_en = cfg_data[0];
					REG_WAVE_SELECT:     wave_sel = wave_t'(cfg_data[1:0]);
					REG_PITCH_OFFSET:    detune = cfg_data[12:0];
					REG_VOLUME:          gain = cfg_data[15:0];
					REG_INV_SAMPLE_RATE: inv_rate = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (samples_due.size() == 0) begin
					$error("sample with nothing expected: got %0d", sample);
					mismatches++;
				end else begin
					want = samples_due.pop_front();
					if (sample !== want) begin
						$error("sample mismatch: expected %0d, got %0d",
							$signed(want), sample);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (action)
					ACT_NOTE_ON: begin
						note_held = note_number;
						gate = 1'b1;
					end
					ACT_NOTE_OFF:
						if (note_number == note_held)
							gate = 1'b0;
					ACT_TICK:
						if (inv_rate != 0)
							samples_due.push_back(tick_sample());
					default: ;
				endcase
			end
		end
		samples_due_count = samples_due.size();
	end

endmodule

>>> verif/multi_wave_phase_oscillator_tb.sv
// Top of the oscillator testbench: clock, reset, note/tick and register stimulus,
// output stall pattern and verdict. Needs mwpo_pkg, the oscillator RTL and osc_sample_checker.
`timescale 1ns / 1ps

module multi_wave_phase_oscillator_tb;
	import mwpo_pkg::*;

	localparam logic [1:0]  ACT_UNUSED = 2'd3;
	localparam logic [39:0] INV_MAX = 40'hFF_FFFF_FFFF;
	localparam logic [39:0] INV_8K  = 40'd35184372088;
	localparam logic [39:0] INV_44K = 40'd6382652533;
	localparam logic [39:0] INV_48K = 40'd5864062014;
	localparam logic [39:0] INV_96K = 40'd2932031007;
	localparam int          RANDOM_PHASES = 12;
	localparam int          ITEMS_PER_PHASE = 58;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           action = ACT_TICK;
	logic [6:0]           note_number = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [15:0]   sample;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = REG_OSC_ENABLED;
	logic [39:0]          cfg_data = '0;

	int samples_due_count;
	int mismatches;
	int burst_left = 0;
	int hold_req = 0;
	int hold_served = 0;

	multi_wave_phase_oscillator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.note_number(note_number),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	osc_sample_checker sample_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.note_number      (note_number),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sample           (sample),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.samples_due_count(samples_due_count),
		.mismatches       (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Output side: stretches of no stall, random stall and periodic stall,
	// plus a long hold-off whenever stimulus asks for one.
	initial begin
		int stretch, mode, period;
		forever begin
			stretch = $urandom_range(20, 200);
			mode = $urandom_range(0, 3);
			period = $urandom_range(2, 6);
			for (int c = 0; c < stretch; c++) begin
				@(posedge clk);
				if (hold_req != hold_served) begin
					out_stall <= 1'b1;
					repeat (400) @(posedge clk);
					hold_served++;
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= (c % period != 0);
				endcase
			end
		end
	end

	// Offer one item, hold it until taken, then maybe end the burst with a gap.
	task automatic offer(input logic [1:0] act, input logic [6:0] nn);
		int gap;
		in_valid <= 1'b1;
		action <= act;
		note_number <= nn;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drain: every sample in, then enough cycles for a note or a silent tick to finish.
	// The first negedge lets the checker count an item taken at the last edge.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (samples_due_count != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [39:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic write_config(input logic en, input wave_t ws, input int off,
			input logic [15:0] vol, input logic [39:0] inv, input bit junk);
		logic [12:0] off13;
		off13 = off[12:0];
		if (junk)
			write_reg(REG_INV_SAMPLE_RATE + 3'($urandom_range(1, 3)),
				40'({$urandom, $urandom}));
		write_reg(REG_OSC_ENABLED, {39'd0, en});
		write_reg(REG_WAVE_SELECT, {38'd0, ws});
		write_reg(REG_PITCH_OFFSET, {{27{off13[12]}}, off13});
		write_reg(REG_VOLUME, {24'd0, vol});
		write_reg(REG_INV_SAMPLE_RATE, inv);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int          r, cnt, off;
		logic [1:0]  act;
		logic [6:0]  nn, last_on;
		logic        en;
		wave_t       ws;
		logic [15:0] vol;
		logic [39:0] inv;
		last_on = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no rate yet, so ticks stay silent
		offer(ACT_TICK, 7'd0);
		offer(ACT_NOTE_ON, 7'd69);
		offer(ACT_TICK, 7'h7F);
		offer(ACT_UNUSED, 7'h55);
		wait_idle();
		write_config(1'b1, WAVE_SAW, 0, RST_VOLUME, INV_48K, 1'b1);
		offer(ACT_TICK, 7'd0);
		offer(ACT_TICK, 7'd0);
		offer(ACT_NOTE_OFF, 7'd60);	// other note, gate stays open
		offer(ACT_TICK, 7'd0);
		offer(ACT_NOTE_OFF, 7'd69);
		offer(ACT_TICK, 7'd0);
		offer(ACT_NOTE_ON, 7'd0);
		offer(ACT_TICK, 7'd0);
		offer(ACT_NOTE_ON, 7'd127);
		offer(ACT_TICK, 7'd0);
		wait_idle();
		// top note, top detune, top rate: step wraps the accumulator
		write_config(1'b1, WAVE_SQUARE, 3072, 16'hFFFF, INV_MAX, 1'b0);
		offer(ACT_TICK, 7'd0);
		offer(ACT_TICK, 7'd0);
		wait_idle();
		write_config(1'b1, WAVE_TRIANGLE, -3072, 16'hFFFF, INV_8K, 1'b0);
		offer(ACT_NOTE_ON, 7'd0);
		offer(ACT_TICK, 7'd0);
		offer(ACT_TICK, 7'd0);
		wait_idle();
		write_config(1'b1, WAVE_SINE, 0, 16'hFFFF, INV_44K, 1'b0);
		offer(ACT_NOTE_ON, 7'd127);
		offer(ACT_TICK, 7'd0);
		offer(ACT_TICK, 7'd0);
		wait_idle();
		write_config(1'b0, WAVE_SINE, 0, 16'hFFFF, INV_96K, 1'b0);
		offer(ACT_TICK, 7'd0);
		last_on = 7'd127;

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			en = ($urandom_range(0, 5) != 0);
			ws = wave_t'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: off = -3072;
				1: off = 3072;
				2: off = 0;
				default: off = int'($urandom_range(0, 6144)) - 3072;
			endcase
			case ($urandom_range(0, 3))
				0: vol = 16'd0;
				1: vol = 16'hFFFF;
				default: vol = 16'($urandom);
			endcase
			case ($urandom_range(0, 11))
				0: inv = '0;
				1: inv = INV_MAX;
				2: inv = INV_8K;
				3, 4: inv = INV_48K;
				5: inv = INV_44K;
				6: inv = INV_96K;
				7: inv = 40'd1;
				default: inv = 40'({$urandom, $urandom});
			endcase
			write_config(en, ws, off, vol, inv, $urandom_range(0, 2) == 0);
			cnt = 0;
			while (cnt < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				nn = 7'($urandom);
				if (r < 62) begin
					act = ACT_TICK;
				end else if (r < 76 || r >= 95) begin
					act = ACT_NOTE_ON;
					last_on = nn;
				end else if (r < 90) begin
					act = ACT_NOTE_OFF;
					if ($urandom_range(0, 1) == 0)
						nn = last_on;
				end else begin
					act = ACT_UNUSED;
				end
				// fill the block while the output side holds off
				if (ph == 3 && cnt == 10)
					hold_req++;
				offer(act, nn);
				if (act != ACT_UNUSED)
					cnt++;
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
